>>> rtl/lrre_pkg.sv
// Shared types and constants for the link request/response engine.
package lrre_pkg;

    localparam int FRAME_BYTES_DEF = 128;

    // stream payload widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MAX_RETRIES     = 2'd0;
    localparam logic [1:0] REG_RESYNC_TRIES    = 2'd1;
    localparam logic [1:0] REG_MAX_REPLY_COUNT = 2'd2;

    localparam logic [3:0] MAX_RETRIES_RST     = 4'd3;
    localparam logic [3:0] RESYNC_TRIES_RST    = 4'd9;
    localparam logic [6:0] MAX_REPLY_COUNT_RST = 7'd125;

    // link bytes
    localparam logic [7:0] BYTE_PRE  = 8'h41;
    localparam logic [7:0] BYTE_NAK  = 8'h05;
    localparam logic [7:0] BYTE_ACK  = 8'h06;
    localparam logic [7:0] BYTE_SYN  = 8'h16;
    localparam logic [7:0] BYTE_ENQ  = 8'h04;
    localparam logic [7:0] DIR_READ  = 8'h01;
    localparam logic [7:0] DIR_WRITE = 8'h02;

    localparam logic [7:0] COUNT_BASE = 8'd5;   // count byte = 5 + write length
    localparam int         HDR_BYTES  = 7;      // preamble through length byte

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_LINK  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_READ   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_NO_ACK    = 3'd2,
        ST_BAD_PRE   = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_TIMEOUT   = 3'd5,
        ST_CHECKSUM  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_COLLECT     = 4'd1,
        PH_SEND        = 4'd2,
        PH_WAIT_ACK    = 4'd3,
        PH_RESYNC_TX   = 4'd4,
        PH_RESYNC_WAIT = 4'd5,
        PH_INIT_SEQ    = 4'd6,
        PH_INIT_WAIT   = 4'd7,
        PH_REPLY_PRE   = 4'd8,
        PH_REPLY_COUNT = 4'd9,
        PH_REPLY_BODY  = 4'd10,
        PH_DELIVER     = 4'd11
    } phase_t;

    // one result word on its way from the control stage to the output
    typedef struct packed {
        logic       valid;
        logic       use_ram;    // byte comes from the frame store read port
        kind_t      kind;
        logic [7:0] byte_value;
        status_t    status;
        logic [6:0] reply_count;
        logic       last;
    } res_t;

endpackage

>>> rtl/link_request_response_engine.sv
// Result words pass the result stage and output registers. Throughput: one input word
// per cycle unless stalled; each word needs at most one frame store access, a read or
// a write on the single RAM port pair, so the store sets the one-word rate.
// Output backpressure stalls s_ only once the result stage and output register are full.
// Reset: synchronous, active low; clears the sequencer to idle and loads register
// defaults. The frame store is not cleared: no entry is read before it is written.
module link_request_response_engine
    import lrre_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // is_write, address[15:0], length[7:0],
                                            // data_byte[7:0], timed_out, zero pad
    input  logic [1:0]            s_tuser,  // command
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // byte_value[7:0], status[2:0],
                                            // reply_count[6:0], zero pad
    output logic [1:0]            m_tuser,  // kind
    output logic                  m_tlast,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [3:0]       max_retries_reg, max_retries_next;
    logic [3:0]       resync_tries_reg, resync_tries_next;
    logic [6:0]       max_reply_count_reg, max_reply_count_next;
    logic             cfg_wr;

    logic             acc;
    res_t             res;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    kind_t            m_kind;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        max_retries_next     = max_retries_reg;
        resync_tries_next    = resync_tries_reg;
        max_reply_count_next = max_reply_count_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_RETRIES:     max_retries_next     = pwdata[3:0];
                REG_RESYNC_TRIES:    resync_tries_next    = pwdata[3:0];
                REG_MAX_REPLY_COUNT: max_reply_count_next = pwdata[6:0];
                default:             max_retries_next     = max_retries_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_RETRIES:     prdata = APB_DATA_W'(max_retries_reg);
            REG_RESYNC_TRIES:    prdata = APB_DATA_W'(resync_tries_reg);
            REG_MAX_REPLY_COUNT: prdata = APB_DATA_W'(max_reply_count_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg     <= MAX_RETRIES_RST;
            resync_tries_reg    <= RESYNC_TRIES_RST;
            max_reply_count_reg <= MAX_REPLY_COUNT_RST;
        end else begin
            max_retries_reg     <= max_retries_next;
            resync_tries_reg    <= resync_tries_next;
            max_reply_count_reg <= max_reply_count_next;
        end
    end

    assign acc = s_tvalid && s_tready;

    lrre_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .acc             (acc),
        .cmd             (cmd_t'(s_tuser)),
        .is_write        (s_tdata[0]),
        .address         (s_tdata[16:1]),
        .length          (s_tdata[24:17]),
        .data_byte       (s_tdata[32:25]),
        .timed_out       (s_tdata[33]),
        .max_retries     (max_retries_reg),
        .resync_tries    (resync_tries_reg),
        .max_reply_count (max_reply_count_reg),
        .res             (res),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr)
    );

    // a write and a later read of one entry never share a cycle; write-then-read
    // in the next cycle sees the new byte, so no bypass is needed
    lrre_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lrre_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_in    (res),
        .ram_rdata (ram_rdata),
        .s_ready   (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata),
        .m_kind    (m_kind),
        .m_last    (m_tlast)
    );

    assign m_tuser = m_kind;

endmodule

>>> rtl/lrre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lrre_ctrl.sv
// Protocol sequencer: framing, ack/resync handling, reply check and frame store access.
module lrre_ctrl
    import lrre_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           acc,
    input  cmd_t                           cmd,
    input  logic                           is_write,
    input  logic [15:0]                    address,
    input  logic [7:0]                     length,
    input  logic [7:0]                     data_byte,
    input  logic                           timed_out,
    input  logic [3:0]                     max_retries,
    input  logic [3:0]                     resync_tries,
    input  logic [6:0]                     max_reply_count,
    output res_t                           res,
    output logic                           ram_we,
    output logic [$clog2(FRAME_BYTES)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr
);

    localparam int IDX_W     = $clog2(FRAME_BYTES);
    localparam int MAX_LEN   = FRAME_BYTES - 8;
    localparam int REPLY_CAP = FRAME_BYTES - 3;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] bi_reg, bi_next;
    logic [IDX_W-1:0] req_len_reg, req_len_next;
    logic             req_wr_reg, req_wr_next;
    logic [3:0]       retries_reg, retries_next;
    logic [3:0]       resync_reg, resync_next;
    logic [7:0]       cks_reg, cks_next;
    logic [6:0]       reply_len_reg, reply_len_next;
    logic [15:0]      addr_reg, addr_next;

    logic             is_start, is_data, is_link, is_tick, tmo_tick;
    logic             len_bad, retry_evt;
    logic [7:0]       start_cnt, start_dir, start_cks;
    logic [IDX_W:0]   send_lastidx, bi_inc;
    logic             send_last, collect_last, deliver_last;
    logic [IDX_W:0]   didx;
    logic             deliver_hit, body_more;
    logic [7:0]       reply_lim;
    logic [7:0]       hdr_byte;

    always_comb begin
        is_start = (cmd == CMD_START);
        is_data  = (cmd == CMD_DATA);
        is_link  = (cmd == CMD_LINK);
        is_tick  = (cmd == CMD_TICK);
        tmo_tick = is_tick && timed_out;

        len_bad   = (length == 8'd0) || (9'(length) > 9'(MAX_LEN));
        start_cnt = COUNT_BASE + (is_write ? length : 8'd0);
        start_dir = is_write ? DIR_WRITE : DIR_READ;
        start_cks = start_cnt + start_dir + address[15:8] + address[7:0] + length;

        bi_inc       = {1'b0, bi_reg} + (IDX_W+1)'(1);
        send_lastidx = (IDX_W+1)'(HDR_BYTES) + (req_wr_reg ? {1'b0, req_len_reg} : '0);
        send_last    = {1'b0, bi_reg} >= send_lastidx;
        collect_last = bi_inc >= {1'b0, req_len_reg};
        deliver_last = collect_last;
        didx         = (IDX_W+1)'(HDR_BYTES) + {1'b0, bi_reg};
        deliver_hit  = 9'(didx) <= (9'(reply_len_reg) + 9'd1);
        body_more    = 8'(bi_reg) < 8'(reply_len_reg);
        reply_lim    = (8'(max_reply_count) > 8'(REPLY_CAP)) ? 8'(REPLY_CAP)
                                                             : 8'(max_reply_count);

        // wrong or missing ack, resync attempts used up, or init answer or timeout seen
        retry_evt = ((phase_reg == PH_WAIT_ACK) &&
                     ((is_link && data_byte != BYTE_ACK && data_byte != BYTE_NAK) ||
                      tmo_tick)) ||
                    ((phase_reg == PH_INIT_WAIT) && (is_link || tmo_tick)) ||
                    ((phase_reg == PH_RESYNC_TX) && is_tick && resync_reg == 4'd0);

        case (bi_reg)
            IDX_W'(0): hdr_byte = BYTE_PRE;
            IDX_W'(1): hdr_byte = COUNT_BASE + (req_wr_reg ? 8'(req_len_reg) : 8'd0);
            IDX_W'(2): hdr_byte = 8'd0;
            IDX_W'(3): hdr_byte = req_wr_reg ? DIR_WRITE : DIR_READ;
            IDX_W'(4): hdr_byte = addr_reg[15:8];
            IDX_W'(5): hdr_byte = addr_reg[7:0];
            default:   hdr_byte = 8'(req_len_reg);
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (acc) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (is_start && !len_bad) begin
                        phase_next = is_write ? PH_COLLECT : PH_SEND;
                    end
                end
                PH_COLLECT: begin
                    if (is_data && collect_last) phase_next = PH_SEND;
                end
                PH_SEND: begin
                    if (is_tick && send_last) phase_next = PH_WAIT_ACK;
                end
                PH_WAIT_ACK: begin
                    if (is_link && data_byte == BYTE_ACK) phase_next = PH_REPLY_PRE;
                    else if (is_link && data_byte == BYTE_NAK) phase_next = PH_RESYNC_TX;
                end
                PH_RESYNC_TX: begin
                    if (is_tick && resync_reg != 4'd0) phase_next = PH_RESYNC_WAIT;
                end
                PH_RESYNC_WAIT: begin
                    if (is_link) begin
                        phase_next = (data_byte == BYTE_NAK) ? PH_INIT_SEQ : PH_RESYNC_TX;
                    end else if (tmo_tick) begin
                        phase_next = PH_RESYNC_TX;
                    end
                end
                PH_INIT_SEQ: begin
                    if (is_tick && bi_reg >= IDX_W'(2)) phase_next = PH_INIT_WAIT;
                end
                PH_INIT_WAIT: begin
                    phase_next = PH_INIT_WAIT;
                end
                PH_REPLY_PRE: begin
                    if (is_link) begin
                        phase_next = (data_byte != BYTE_PRE) ? PH_IDLE : PH_REPLY_COUNT;
                    end else if (tmo_tick) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_REPLY_COUNT: begin
                    if (is_link) begin
                        phase_next = (data_byte > reply_lim) ? PH_IDLE : PH_REPLY_BODY;
                    end else if (tmo_tick) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_REPLY_BODY: begin
                    if (is_link && !body_more) begin
                        phase_next = (data_byte != cks_reg || req_wr_reg) ? PH_IDLE
                                                                          : PH_DELIVER;
                    end else if (tmo_tick) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DELIVER: begin
                    if (is_tick && deliver_last) phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
            if (retry_evt) begin
                phase_next = (retries_reg == 4'd0) ? PH_IDLE : PH_SEND;
            end
        end
    end

    // datapath registers, result word and store access
    always_comb begin
        bi_next        = bi_reg;
        req_len_next   = req_len_reg;
        req_wr_next    = req_wr_reg;
        retries_next   = retries_reg;
        resync_next    = resync_reg;
        cks_next       = cks_reg;
        reply_len_next = reply_len_reg;
        addr_next      = addr_reg;
        res            = '0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = data_byte;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (acc) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (is_start && len_bad) begin
                        res.valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_BAD_LEN;
                        bi_next    = '0;
                    end else if (is_start) begin
                        req_wr_next  = is_write;
                        req_len_next = length[IDX_W-1:0];
                        addr_next    = address;
                        cks_next     = start_cks;
                        retries_next = max_retries;
                        bi_next      = '0;
                    end
                end
                PH_COLLECT: begin
                    if (is_data) begin
                        ram_we    = 1'b1;
                        ram_waddr = didx[IDX_W-1:0];
                        cks_next  = cks_reg + data_byte;
                        bi_next   = collect_last ? '0 : bi_inc[IDX_W-1:0];
                    end
                end
                PH_SEND: begin
                    if (is_tick) begin
                        res.valid = 1'b1;
                        res.kind  = KIND_TX;
                        res.last  = send_last;
                        if (send_last) begin
                            res.byte_value = cks_reg;
                        end else if (bi_reg < IDX_W'(HDR_BYTES)) begin
                            res.byte_value = hdr_byte;
                        end else begin
                            res.use_ram = 1'b1;
                            ram_re      = 1'b1;
                            ram_raddr   = bi_reg;
                        end
                        bi_next = send_last ? '0 : bi_inc[IDX_W-1:0];
                    end
                end
                PH_WAIT_ACK: begin
                    if (is_link && data_byte == BYTE_NAK) resync_next = resync_tries;
                end
                PH_RESYNC_TX: begin
                    if (is_tick && resync_reg != 4'd0) begin
                        resync_next    = resync_reg - 4'd1;
                        res.valid      = 1'b1;
                        res.kind       = KIND_TX;
                        res.byte_value = BYTE_ENQ;
                        res.last       = 1'b1;
                    end
                end
                PH_RESYNC_WAIT: begin
                    if (is_link && data_byte == BYTE_NAK) bi_next = '0;
                end
                PH_INIT_SEQ: begin
                    if (is_tick) begin
                        res.valid      = 1'b1;
                        res.kind       = KIND_TX;
                        res.byte_value = (bi_reg == '0) ? BYTE_SYN : 8'd0;
                        res.last       = bi_reg >= IDX_W'(2);
                        bi_next        = res.last ? '0 : bi_inc[IDX_W-1:0];
                    end
                end
                PH_REPLY_PRE: begin
                    if ((is_link && data_byte != BYTE_PRE) || tmo_tick) begin
                        res.valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_BAD_PRE;
                        bi_next    = '0;
                    end
                end
                PH_REPLY_COUNT: begin
                    if ((is_link && data_byte > reply_lim) || tmo_tick) begin
                        res.valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_BAD_COUNT;
                        bi_next    = '0;
                    end else if (is_link) begin
                        reply_len_next = data_byte[6:0];
                        cks_next       = data_byte;
                        bi_next        = '0;
                    end
                end
                PH_REPLY_BODY: begin
                    if (is_link) begin
                        // reply body lands at offset 2 so data bytes line up with index 7
                        ram_we    = 1'b1;
                        ram_waddr = bi_reg + IDX_W'(2);
                        if (body_more) begin
                            cks_next = cks_reg + data_byte;
                            bi_next  = bi_inc[IDX_W-1:0];
                        end else begin
                            res.valid   = 1'b1;
                            res.kind    = KIND_STATUS;
                            bi_next     = '0;
                            if (data_byte != cks_reg) begin
                                res.status = ST_CHECKSUM;
                            end else begin
                                res.status      = ST_OK;
                                res.reply_count = reply_len_reg;
                            end
                        end
                    end else if (tmo_tick) begin
                        res.valid  = 1'b1;
                        res.kind   = KIND_STATUS;
                        res.status = ST_TIMEOUT;
                        bi_next    = '0;
                    end
                end
                PH_DELIVER: begin
                    if (is_tick) begin
                        res.valid = 1'b1;
                        res.kind  = KIND_READ;
                        res.last  = deliver_last;
                        if (deliver_hit) begin
                            res.use_ram = 1'b1;
                            ram_re      = 1'b1;
                            ram_raddr   = didx[IDX_W-1:0];
                        end
                        bi_next = deliver_last ? '0 : bi_inc[IDX_W-1:0];
                    end
                end
                default: begin
                    bi_next = bi_reg;
                end
            endcase

            if (retry_evt) begin
                bi_next = '0;
                if (retries_reg == 4'd0) begin
                    res        = '0;
                    res.valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.status = ST_NO_ACK;
                end else begin
                    retries_next = retries_reg - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bi_reg        <= '0;
            req_len_reg   <= '0;
            req_wr_reg    <= 1'b0;
            retries_reg   <= '0;
            resync_reg    <= '0;
            cks_reg       <= '0;
            reply_len_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            bi_reg        <= bi_next;
            req_len_reg   <= req_len_next;
            req_wr_reg    <= req_wr_next;
            retries_reg   <= retries_next;
            resync_reg    <= resync_next;
            cks_reg       <= cks_next;
            reply_len_reg <= reply_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

endmodule

>>> rtl/lrre_out.sv
// Result stage aligned with the store read, followed by the output register.
module lrre_out
    import lrre_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  res_t                res_in,
    input  logic [7:0]          ram_rdata,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [M_DATA_W-1:0] m_data,
    output kind_t               m_kind,
    output logic                m_last
);

    res_t       s1_reg, s1_next;
    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    status_t    out_status_reg, out_status_next;
    logic [6:0] out_count_reg, out_count_next;
    logic       out_last_reg, out_last_next;
    logic       s1_adv;

    always_comb begin
        s1_adv  = !out_valid_reg || m_ready;
        s_ready = !s1_reg.valid || s1_adv;

        s1_next = s1_reg;
        if (s_ready) begin
            s1_next = res_in;
        end

        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (s1_adv) begin
            out_valid_next  = s1_reg.valid;
            out_kind_next   = s1_reg.kind;
            out_byte_next   = s1_reg.use_ram ? ram_rdata : s1_reg.byte_value;
            out_status_next = s1_reg.status;
            out_count_next  = s1_reg.reply_count;
            out_last_next   = s1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_reg        <= s1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_last  = out_last_reg;
    assign m_data  = M_DATA_W'({out_count_reg, out_status_reg, out_byte_reg});

    // a full stage that cannot move must stall the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_reg.valid && !s1_adv) |-> !s_ready)
        else $error("input accepted while result stage is blocked");

    // a result word taken in reaches the stage register
    a_result_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_in.valid && s_ready) |=> s1_reg.valid)
        else $error("result word lost on entry");

    // a blocked stage keeps its word, so the store read data stays paired with it
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_reg.valid && !s1_adv) |=> (s1_reg.valid && $stable(s1_reg)))
        else $error("result stage changed while blocked");

endmodule

>>> verif/link_engine_checker.sv
// Result checker for the link request/response engine: register copies and a predictor.
module link_engine_checker
    import lrre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // is_write, address[15:0], length[7:0],
                                            // data_byte[7:0], timed_out, zero pad
    input  logic [1:0]            s_tuser,  // command
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,  // byte_value[7:0], status[2:0],
                                            // reply_count[6:0], zero pad
    input  logic [1:0]            m_tuser,  // kind
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    words_pending,
    output phase_t                engine_phase
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES   = FRAME_BYTES_DEF;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        status_t    status;
        logic [6:0] reply_count;
        logic       last;
    } link_result_t;

    link_result_t due_results[$];
    link_result_t want;
    link_result_t got;

    // register copies
    logic [3:0] cfg_retries;
    logic [3:0] cfg_resync;
    logic [6:0] cfg_reply_max;

    // engine state copy
    phase_t      seq_phase;
    logic [7:0]  frame[FRAME_BYTES];
    int unsigned seq_index;
    int unsigned req_len;
    logic        req_wr;
    int unsigned retries_left;
    int unsigned resync_left;
    int unsigned csum;
    int unsigned reply_len;

    int mismatches;

    function automatic void post_result(kind_t kind, logic [7:0] val, status_t st,
                                        logic [6:0] cnt, logic lst);
        link_result_t r;
        r.kind        = kind;
        r.byte_value  = val;
        r.status      = st;
        r.reply_count = cnt;
        r.last        = lst;
        due_results.push_back(r);
    endfunction

    function automatic void abort_request(status_t st);
        seq_phase = PH_IDLE;
        seq_index = 0;
        post_result(KIND_STATUS, 8'd0, st, 7'd0, 1'b0);
    endfunction

    // bad or missing ack, or the end of a resync: resend the frame or give up
    function automatic void resend_or_abort();
        if (retries_left == 0) begin
            abort_request(ST_NO_ACK);
        end else begin
            retries_left--;
            seq_phase = PH_SEND;
            seq_index = 0;
        end
    endfunction

    function automatic void sequence_link_word(cmd_t cmd, logic wr, logic [15:0] addr,
                                               logic [7:0] len, logic [7:0] d, logic tmo);
        int unsigned w;
        int unsigned dir;
        int unsigned lim;
        int unsigned pos;
        logic [7:0]  v;
        logic        lst;
        case (cmd)
            CMD_START: begin
                if (seq_phase == PH_IDLE) begin
                    if (len == 0 || len > FRAME_BYTES - 8) begin
                        abort_request(ST_BAD_LEN);
                    end else begin
                        req_wr   = wr;
                        req_len  = len;
                        w        = wr ? len : 0;
                        dir      = wr ? DIR_WRITE : DIR_READ;
                        frame[0] = BYTE_PRE;
                        frame[1] = 8'(COUNT_BASE + w);
                        frame[2] = 8'd0;
                        frame[3] = 8'(dir);
                        frame[4] = addr[15:8];
                        frame[5] = addr[7:0];
                        frame[6] = len;
                        csum = (COUNT_BASE + w + dir + addr[15:8] + addr[7:0] + len) & 8'hFF;
                        retries_left = cfg_retries;
                        seq_index = 0;
                        if (wr) begin
                            seq_phase = PH_COLLECT;
                        end else begin
                            frame[HDR_BYTES] = 8'(csum);
                            seq_phase = PH_SEND;
                        end
                    end
                end
            end
            CMD_DATA: begin
                if (seq_phase == PH_COLLECT) begin
                    frame[HDR_BYTES + seq_index] = d;
                    csum = (csum + d) & 8'hFF;
                    seq_index++;
                    if (seq_index >= req_len) begin
                        frame[HDR_BYTES + req_len] = 8'(csum);
                        seq_index = 0;
                        seq_phase = PH_SEND;
                    end
                end
            end
            CMD_LINK: begin
                case (seq_phase)
                    PH_WAIT_ACK: begin
                        if (d == BYTE_ACK) begin
                            seq_phase = PH_REPLY_PRE;
                        end else if (d == BYTE_NAK) begin
                            resync_left = cfg_resync;
                            seq_phase = PH_RESYNC_TX;
                        end else begin
                            resend_or_abort();
                        end
                    end
                    PH_RESYNC_WAIT: begin
                        if (d == BYTE_NAK) begin
                            seq_index = 0;
                            seq_phase = PH_INIT_SEQ;
                        end else begin
                            seq_phase = PH_RESYNC_TX;
                        end
                    end
                    PH_INIT_WAIT: resend_or_abort();
                    PH_REPLY_PRE: begin
                        if (d != BYTE_PRE) abort_request(ST_BAD_PRE);
                        else seq_phase = PH_REPLY_COUNT;
                    end
                    PH_REPLY_COUNT: begin
                        lim = (cfg_reply_max > FRAME_BYTES - 3) ? FRAME_BYTES - 3
                                                                : cfg_reply_max;
                        if (d > lim) begin
                            abort_request(ST_BAD_COUNT);
                        end else begin
                            frame[1]  = d;
                            reply_len = d;
                            csum      = d;
                            seq_index = 0;
                            seq_phase = PH_REPLY_BODY;
                        end
                    end
                    PH_REPLY_BODY: begin
                        frame[2 + seq_index] = d;
                        if (seq_index < reply_len) begin
                            csum = (csum + d) & 8'hFF;
                            seq_index++;
                        end else if (d != csum) begin
                            abort_request(ST_CHECKSUM);
                        end else begin
                            seq_index = 0;
                            seq_phase = req_wr ? PH_IDLE : PH_DELIVER;
                            post_result(KIND_STATUS, 8'd0, ST_OK, 7'(reply_len), 1'b0);
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                case (seq_phase)
                    PH_SEND: begin
                        v   = frame[seq_index];
                        lst = seq_index >= HDR_BYTES + (req_wr ? req_len : 0);
                        if (lst) begin
                            seq_phase = PH_WAIT_ACK;
                            seq_index = 0;
                        end else begin
                            seq_index++;
                        end
                        post_result(KIND_TX, v, ST_OK, 7'd0, lst);
                    end
                    PH_RESYNC_TX: begin
                        if (resync_left == 0) begin
                            resend_or_abort();
                        end else begin
                            resync_left--;
                            seq_phase = PH_RESYNC_WAIT;
                            post_result(KIND_TX, BYTE_ENQ, ST_OK, 7'd0, 1'b1);
                        end
                    end
                    PH_INIT_SEQ: begin
                        v   = (seq_index == 0) ? BYTE_SYN : 8'd0;
                        lst = seq_index >= 2;
                        if (lst) begin
                            seq_phase = PH_INIT_WAIT;
                            seq_index = 0;
                        end else begin
                            seq_index++;
                        end
                        post_result(KIND_TX, v, ST_OK, 7'd0, lst);
                    end
                    PH_DELIVER: begin
                        // bytes past a short reply read as zero
                        pos = HDR_BYTES + seq_index;
                        v   = (pos <= reply_len + 1) ? frame[pos] : 8'd0;
                        lst = seq_index + 1 >= req_len;
                        if (lst) begin
                            seq_phase = PH_IDLE;
                            seq_index = 0;
                        end else begin
                            seq_index++;
                        end
                        post_result(KIND_READ, v, ST_OK, 7'd0, lst);
                    end
                    PH_WAIT_ACK, PH_INIT_WAIT: if (tmo) resend_or_abort();
                    PH_RESYNC_WAIT: if (tmo) seq_phase = PH_RESYNC_TX;
                    PH_REPLY_PRE:   if (tmo) abort_request(ST_BAD_PRE);
                    PH_REPLY_COUNT: if (tmo) abort_request(ST_BAD_COUNT);
                    PH_REPLY_BODY:  if (tmo) abort_request(ST_TIMEOUT);
                    default: ;
                endcase
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_retries   = MAX_RETRIES_RST;
            cfg_resync    = RESYNC_TRIES_RST;
            cfg_reply_max = MAX_REPLY_COUNT_RST;
            seq_phase     = PH_IDLE;
            seq_index     = 0;
            req_len       = 0;
            req_wr        = 1'b0;
            retries_left  = 0;
            resync_left   = 0;
            csum          = 0;
            reply_len     = 0;
            mismatches    = 0;
            for (int i = 0; i < FRAME_BYTES; i++) frame[i] = 8'd0;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_MAX_RETRIES:     cfg_retries   = pwdata[3:0];
                    REG_RESYNC_TRIES:    cfg_resync    = pwdata[3:0];
                    REG_MAX_REPLY_COUNT: cfg_reply_max = pwdata[6:0];
                    default: ;
                endcase
            end
            // a word leaving now was caused by an earlier input, so check before predicting
            if (m_tvalid && m_tready) begin
                got.kind        = kind_t'(m_tuser);
                got.byte_value  = m_tdata[7:0];
                got.status      = status_t'(m_tdata[10:8]);
                got.reply_count = m_tdata[17:11];
                got.last        = m_tlast;
                // fields shown as kind/byte/status/count/last
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no word, got %0d/%02h/%0d/%0d/%0d", $time,
                             got.kind, got.byte_value, got.status, got.reply_count,
                             got.last);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected %0d/%02h/%0d/%0d/%0d, got %0d/%02h/%0d/%0d/%0d",
                                 $time, want.kind, want.byte_value, want.status,
                                 want.reply_count, want.last, got.kind, got.byte_value,
                                 got.status, got.reply_count, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                sequence_link_word(cmd_t'(s_tuser), s_tdata[0], s_tdata[16:1], s_tdata[24:17],
                                   s_tdata[32:25], s_tdata[33]);
        end
        engine_phase  <= seq_phase;
        words_pending <= due_results.size();
        fail_count    <= mismatches;
    end

endmodule

>>> verif/link_request_response_engine_tb.sv
// Testbench top for the link request/response engine: clock, reset, stimulus and verdict.
module link_request_response_engine_tb
    import lrre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY = 2;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_WORDS   = 800;
    localparam int PHASES         = 5;

    typedef struct packed {
        cmd_t        cmd;
        logic        is_write;
        logic [15:0] address;
        logic [7:0]  length;
        logic [7:0]  data_byte;
        logic        timed_out;
    } link_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;  // is_write, address[15:0], length[7:0],
                                     // data_byte[7:0], timed_out, zero pad
    logic [1:0]            s_tuser;  // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_DATA_W-1:0]   m_tdata;  // byte_value[7:0], status[2:0], reply_count[6:0], zero pad
    logic [1:0]            m_tuser;  // kind
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int     fail_count;
    int     words_pending;
    phase_t engine_phase;

    link_word_t  link_script[$];
    int unsigned words_made = 0;
    int unsigned burst_left = 0;
    logic [3:0]  cfg_retries_now   = MAX_RETRIES_RST;
    logic [3:0]  cfg_resync_now    = RESYNC_TRIES_RST;
    logic [6:0]  cfg_reply_max_now = MAX_REPLY_COUNT_RST;

    int unsigned ready_span = 0;
    logic [1:0]  ready_mode = 2'd0;

    link_request_response_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    link_engine_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .engine_phase  (engine_phase)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: spans of always-ready, light stalls, heavy stalls and alternating
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_mode <= 2'($urandom_range(0, 3));
            ready_span <= $urandom_range(20, 300);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= $urandom_range(0, 3) != 0;
            2'd2:    m_tready <= $urandom_range(0, 3) == 0;
            default: m_tready <= ~m_tready;
        endcase
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic void add_word(cmd_t cmd, logic [7:0] d, logic tmo);
        link_word_t w;
        w.cmd       = cmd;
        w.is_write  = 1'($urandom);
        w.address   = 16'($urandom);
        w.length    = 8'($urandom);
        w.data_byte = d;
        w.timed_out = tmo;
        link_script.push_back(w);
        words_made++;
    endfunction

    function automatic void add_start(logic wr, logic [15:0] addr, logic [7:0] len);
        link_word_t w;
        w.cmd       = CMD_START;
        w.is_write  = wr;
        w.address   = addr;
        w.length    = len;
        w.data_byte = 8'($urandom);
        w.timed_out = 1'($urandom);
        link_script.push_back(w);
        words_made++;
    endfunction

    // ticks that each move one byte out; now and then a stray word the engine ignores
    function automatic void add_byte_ticks(int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 24) == 0)
                add_word(cmd_t'($urandom_range(1, 2)), 8'($urandom), 1'($urandom));
            add_word(CMD_TICK, 8'($urandom), 1'($urandom));
        end
    endfunction

    // one request from start to its end, mostly well formed
    task automatic build_request();
        logic        wr;
        logic [7:0]  len;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned tries;
        int unsigned fails;
        int unsigned lim;
        int unsigned cnt;
        int unsigned cut;
        int unsigned sum;
        bit          acked;
        bit          done;
        wr   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2)       len = 8'd0;
        else if (pick < 4)  len = 8'($urandom_range(FRAME_BYTES_DEF - 7, 255));
        else if (pick < 10) len = 8'($urandom_range(9, FRAME_BYTES_DEF - 8));
        else                len = 8'($urandom_range(1, 8));
        add_start(wr, 16'($urandom), len);
        if (len == 0 || len > FRAME_BYTES_DEF - 8) return;
        if ($urandom_range(0, 9) == 0) add_start(1'($urandom), 16'($urandom), 8'($urandom));
        if (wr) begin
            repeat (len) begin
                if ($urandom_range(0, 19) == 0)
                    add_word(cmd_t'($urandom_range(2, 3)), 8'($urandom), 1'($urandom));
                add_word(CMD_DATA, 8'($urandom), 1'($urandom));
            end
        end
        tries = cfg_retries_now;
        acked = 1'b0;
        done  = 1'b0;
        while (!done) begin
            add_byte_ticks(wr ? HDR_BYTES + 1 + len : HDR_BYTES + 1);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                if ($urandom_range(0, 3) == 0) add_word(CMD_TICK, 8'($urandom), 1'b0);
                add_word(CMD_LINK, BYTE_ACK, 1'($urandom));
                acked = 1'b1;
                done  = 1'b1;
            end else begin
                if (pick == 6) begin
                    add_word(CMD_LINK, BYTE_NAK, 1'($urandom));
                    fails = $urandom_range(0, cfg_resync_now);
                    repeat (fails) begin
                        add_word(CMD_TICK, 8'($urandom), 1'($urandom));
                        if ($urandom_range(0, 1)) begin
                            add_word(CMD_TICK, 8'($urandom), 1'b1);
                        end else begin
                            do b = 8'($urandom); while (b == BYTE_NAK);
                            add_word(CMD_LINK, b, 1'($urandom));
                        end
                    end
                    if (fails == cfg_resync_now) begin
                        // attempts used up: the next tick ends the resync
                        add_word(CMD_TICK, 8'($urandom), 1'($urandom));
                    end else begin
                        add_word(CMD_TICK, 8'($urandom), 1'($urandom));
                        add_word(CMD_LINK, BYTE_NAK, 1'($urandom));
                        add_byte_ticks(3);
                        if ($urandom_range(0, 1)) add_word(CMD_LINK, 8'($urandom), 1'($urandom));
                        else add_word(CMD_TICK, 8'($urandom), 1'b1);
                    end
                end else if (pick == 7) begin
                    do b = 8'($urandom); while (b == BYTE_NAK || b == BYTE_ACK);
                    add_word(CMD_LINK, b, 1'($urandom));
                end else begin
                    add_word(CMD_TICK, 8'($urandom), 1'b1);
                end
                if (tries == 0) done = 1'b1;
                else tries--;
            end
        end
        if (!acked) return;

        lim  = (cfg_reply_max_now > FRAME_BYTES_DEF - 3) ? FRAME_BYTES_DEF - 3
                                                         : cfg_reply_max_now;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            add_word(CMD_TICK, 8'($urandom), 1'b1);
            return;
        end
        if (pick == 1) begin
            do b = 8'($urandom); while (b == BYTE_PRE);
            add_word(CMD_LINK, b, 1'($urandom));
            return;
        end
        add_word(CMD_LINK, BYTE_PRE, 1'($urandom));
        if (pick == 2) begin
            add_word(CMD_LINK, 8'($urandom_range(lim + 1, 255)), 1'($urandom));
            return;
        end
        if (pick == 3) begin
            add_word(CMD_TICK, 8'($urandom), 1'b1);
            return;
        end
        if (!wr && len + 5 <= lim && $urandom_range(0, 2) != 0) cnt = len + 5;
        else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, lim);
        else cnt = $urandom_range(0, (lim < 12) ? lim : 12);
        add_word(CMD_LINK, 8'(cnt), 1'($urandom));
        cut = (pick == 4) ? $urandom_range(0, cnt) : cnt + 1;
        sum = cnt;
        for (int i = 0; i < cnt; i++) begin
            if (i == cut) break;
            if ($urandom_range(0, 7) == 0) add_word(CMD_TICK, 8'($urandom), 1'b0);
            b = 8'($urandom);
            sum += b;
            add_word(CMD_LINK, b, 1'($urandom));
        end
        if (pick == 4) begin
            add_word(CMD_TICK, 8'($urandom), 1'b1);
            return;
        end
        if (pick == 5) begin
            add_word(CMD_LINK, 8'(sum + $urandom_range(1, 255)), 1'($urandom));
            return;
        end
        add_word(CMD_LINK, 8'(sum), 1'($urandom));
        if (!wr) add_byte_ticks(len);
    endtask

    task automatic play_script();
        link_word_t  w;
        int unsigned gap;
        while (link_script.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
                gap = $urandom_range(0, 4);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            w = link_script.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {6'd0, w.timed_out, w.data_byte, w.length, w.address, w.is_write};
            s_tuser  <= w.cmd;
            do @(negedge aclk); while (!s_tready);
            @(posedge aclk);
            burst_left--;
        end
    endtask

    // bring the engine back to idle whatever state the last words left it in
    task automatic settle_engine();
        bit idle;
        idle = 1'b0;
        while (!idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            if (engine_phase == PH_IDLE) begin
                idle = 1'b1;
            end else begin
                if (engine_phase == PH_COLLECT) add_word(CMD_DATA, 8'($urandom), 1'($urandom));
                else add_word(CMD_TICK, 8'($urandom), 1'b1);
                play_script();
            end
        end
    endtask

    task automatic drain_results();
        while (words_pending != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [3:0] retries, logic [3:0] resync, logic [6:0] reply_max);
        write_register(REG_MAX_RETRIES, APB_DATA_W'(retries));
        write_register(REG_RESYNC_TRIES, APB_DATA_W'(resync));
        write_register(REG_MAX_REPLY_COUNT, APB_DATA_W'(reply_max));
        cfg_retries_now   = retries;
        cfg_resync_now    = resync;
        cfg_reply_max_now = reply_max;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_START;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: stray words while idle, bad lengths, then a minimal write with an empty reply
        add_word(CMD_TICK, 8'hFF, 1'b1);
        add_word(CMD_LINK, BYTE_ACK, 1'b0);
        add_word(CMD_DATA, 8'h00, 1'b0);
        add_start(1'b0, 16'h0000, 8'd0);
        add_start(1'b1, 16'hFFFF, 8'(FRAME_BYTES_DEF - 7));
        add_start(1'b0, 16'hA5A5, 8'hFF);
        add_start(1'b1, 16'hFFFF, 8'd1);
        add_word(CMD_DATA, 8'hFF, 1'b1);
        add_byte_ticks(HDR_BYTES + 2);
        add_word(CMD_LINK, BYTE_ACK, 1'b0);
        add_word(CMD_LINK, BYTE_PRE, 1'b1);
        add_word(CMD_LINK, 8'h00, 1'b0);
        add_word(CMD_LINK, 8'h00, 1'b1);
        play_script();
        settle_engine();

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain_results();
                case (p)
                    1: apply_settings(4'd0, 4'd1, 7'd1);
                    2: apply_settings(4'd15, 4'd15, 7'd125);
                    3: apply_settings(4'($urandom_range(0, 15)), 4'($urandom_range(1, 15)),
                                      7'($urandom_range(1, 125)));
                    default: apply_settings(4'($urandom_range(1, 4)), 4'($urandom_range(1, 3)),
                                            7'($urandom_range(20, 125)));
                endcase
            end
            words_made = 0;
            while (words_made < RANDOM_WORDS / PHASES) begin
                if ($urandom_range(0, 19) == 0) begin
                    repeat ($urandom_range(1, 5))
                        add_word(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                end else begin
                    build_request();
                end
                play_script();
                settle_engine();
            end
        end

        drain_results();
        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/lrre_pkg.sv
rtl/lrre_ram.sv
rtl/lrre_ctrl.sv
rtl/lrre_out.sv
rtl/link_request_response_engine.sv
verif/link_engine_checker.sv
verif/link_request_response_engine_tb.sv
